[sv/mmhp_pkg.sv]
// shared constants, codes and level geometry helpers for the min/max height pyramid
package mmhp_pkg;

	localparam int LEVEL_COUNT_DEF = 7;
	localparam int GRID_SIDE_DEF   = 64;

	localparam int POS_W  = 32;
	localparam int EXT_W  = 31;
	localparam int HGT_W  = 16;
	localparam int OUT_W  = 17;
	localparam int OFS_W  = 15;
	localparam int CHK_W  = 5;
	localparam int CELL_W = 6;
	localparam int LVL_W  = 4;
	localparam int CFG_IW = 3;
	localparam int SHV_W  = 42;
	localparam int SHA_W  = 6;
	localparam int FRC_W  = 8;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_PATCH = 2'd1;
	localparam logic [1:0] OP_POINT = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_CHUNK    = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_DOWN     = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_UP       = 3'd4;

	localparam logic [CHK_W-1:0] CHUNK_RESET = 5'd8;

	function automatic int lvl_side(input int g, input int k);
		int s;
		s = g >> k;
		if (s == 0) s = 1;
		return s;
	endfunction

	function automatic int lvl_base(input int g, input int k);
		int b;
		b = 0;
		for (int j = 0; j < k; j++) b = b + lvl_side(g, j) * lvl_side(g, j);
		return b;
	endfunction

	function automatic int store_depth(input int g, input int l);
		return lvl_base(g, l);
	endfunction

endpackage

[sv/minmax_height_pyramid_core.sv]
// top level: sequencer, configuration registers and store of the min/max height pyramid
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data            | in
//  in      | in_valid in_ready op cell_x cell_y height_min     | in
//          | height_max level pos_x pos_y patch_extent         |
//  out     | out_valid out_ready out_min out_max               | out
//
// after reset the store is swept to zero, one entry a cycle (5461 entries at the defaults);
// no beat is taken on the input channel meanwhile, configuration beats are taken always.
// a write stores the base cell, then rebuilds each level up to LEVEL_COUNT-1 from the four child
// reads per level on the single store port; a patch or point query uses the shared shift unit (not
// at the top level), the store port and, for a point query, the shared lerp multiplier. a
// finished result waits in the output register; the next beat is taken meanwhile, and a
// query stalls before its result only while an earlier result is still untaken.
module minmax_height_pyramid_core import mmhp_pkg::*; #(
	parameter int LEVEL_COUNT = LEVEL_COUNT_DEF,
	parameter int GRID_SIDE   = GRID_SIDE_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IW-1:0]       cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              op,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	input  logic signed [HGT_W-1:0] height_min,
	input  logic signed [HGT_W-1:0] height_max,
	input  logic [LVL_W-1:0]        level,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic [EXT_W-1:0]        patch_extent,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] out_min,
	output logic signed [OUT_W-1:0] out_max
);

	localparam int CW    = $clog2(GRID_SIDE);
	localparam int LW    = $clog2(LEVEL_COUNT);
	localparam int DEPTH = store_depth(GRID_SIDE, LEVEL_COUNT);
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [8:0] {
		ST_CLR   = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_WBASE = 9'b000000100,
		ST_WRD   = 9'b000001000,
		ST_WWR   = 9'b000010000,
		ST_QSH   = 9'b000100000,
		ST_QRD   = 9'b001000000,
		ST_QCMB  = 9'b010000000,
		ST_QFIN  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [2:0]    stp_q;
	logic [AW-1:0] clr_q;

	logic signed [POS_W-1:0] origin_x_q, origin_y_q;
	logic [CHK_W-1:0]        chunk_q;
	logic [OFS_W-1:0]        down_q, up_q;

	logic [CW-1:0]  cx_q, cy_q;
	logic [31:0]    wdat_q;
	logic [LW-1:0]  wk_q;
	logic signed [HGT_W-1:0] acc_min_q, acc_max_q;

	logic                    point_q;
	logic [LW-1:0]           qlv_q;
	logic signed [POS_W-1:0] px_q, py_q;
	logic [EXT_W-1:0]        ext_q;
	logic [CW-1:0]           sx_q, sy_q, ex_q, ey_q;
	logic [FRC_W-1:0]        fx_q, fy_q;
	logic [31:0]             c_q [4];
	logic signed [HGT_W-1:0] t_q [4];
	logic signed [HGT_W-1:0] res_min_q, res_max_q;

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_min_q, out_max_q;

	logic [CW:0]   side_tab [LEVEL_COUNT];
	logic [AW-1:0] base_tab [LEVEL_COUNT];

	always_comb begin
		for (int k = 0; k < LEVEL_COUNT; k++) begin
			side_tab[k] = (CW+1)'(lvl_side(GRID_SIDE, k));
			base_tab[k] = AW'(lvl_base(GRID_SIDE, k));
		end
	end

	// parent and child coordinates of the upward walk
	logic [LW-1:0] wkc;
	logic [CW-1:0] wpx, wpy, wchx, wchy;
	logic [CW-1:0] shx, shy;
	logic [CW:0]   cxx, cxy, lim_p, lim_c;

	always_comb begin
		wkc   = wk_q - LW'(1);
		lim_p = side_tab[wk_q] - (CW+1)'(1);
		lim_c = side_tab[wkc] - (CW+1)'(1);
		shx   = cx_q >> wk_q;
		shy   = cy_q >> wk_q;
		wpx   = ({1'b0, shx} > lim_p) ? lim_p[CW-1:0] : shx;
		wpy   = ({1'b0, shy} > lim_p) ? lim_p[CW-1:0] : shy;
		cxx   = {wpx, stp_q[0]};
		cxy   = {wpy, stp_q[1]};
		wchx  = (cxx > lim_c) ? lim_c[CW-1:0] : cxx[CW-1:0];
		wchy  = (cxy > lim_c) ? lim_c[CW-1:0] : cxy[CW-1:0];
	end

	// store address from level and cell
	logic [LW-1:0]   alv;
	logic [CW-1:0]   ax, ay;
	logic [2*CW:0]   prod;
	logic [AW-1:0]   mem_addr;
	logic            mem_we;
	logic [31:0]     mem_wdata, mem_rdata;

	always_comb begin
		alv = qlv_q;
		ax  = stp_q[0] ? ex_q : sx_q;
		ay  = stp_q[1] ? ey_q : sy_q;
		unique case (state_q)
			ST_WBASE: begin
				alv = '0;
				ax  = cx_q;
				ay  = cy_q;
			end
			ST_WRD: begin
				alv = wkc;
				ax  = wchx;
				ay  = wchy;
			end
			ST_WWR: begin
				alv = wk_q;
				ax  = wpx;
				ay  = wpy;
			end
			default: begin
			end
		endcase
		prod = (2*CW+1)'(ay) * (2*CW+1)'(side_tab[alv]);
		mem_addr = (state_q == ST_CLR) ? clr_q : base_tab[alv] + AW'(prod) + AW'(ax);
		mem_we = 1'b0;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLR:   mem_we = 1'b1;
			ST_WBASE: begin
				mem_we    = 1'b1;
				mem_wdata = wdat_q;
			end
			ST_WWR: begin
				mem_we    = 1'b1;
				mem_wdata = {acc_max_q, acc_min_q};
			end
			default: begin
			end
		endcase
	end

	mmhp_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// shift unit operands: start x, start y, end x, end y
	logic signed [POS_W:0]   dxo, dyo;
	logic signed [SHV_W-1:0] sh_val;
	logic [SHA_W-1:0]        sh_amt;
	logic [CW-1:0]           sh_coord;
	logic [FRC_W-1:0]        sh_frac;

	always_comb begin
		dxo = (POS_W+1)'(px_q) - (POS_W+1)'(origin_x_q);
		dyo = (POS_W+1)'(py_q) - (POS_W+1)'(origin_y_q);
		sh_amt = SHA_W'(chunk_q) + SHA_W'(qlv_q);
		if (point_q) begin
			sh_val = stp_q[0] ? (SHV_W'(dyo) <<< FRC_W) : (SHV_W'(dxo) <<< FRC_W);
		end else if (stp_q[1]) begin
			sh_val = (stp_q[0] ? SHV_W'(dyo) : SHV_W'(dxo)) + $signed(SHV_W'(ext_q));
		end else begin
			sh_val = stp_q[0] ? SHV_W'(dyo) : SHV_W'(dxo);
		end
	end

	mmhp_shift #(.CW(CW)) u_shift (
		.val   (sh_val),
		.amt   (sh_amt),
		.point (point_q),
		.inc   (stp_q[1]),
		.side  (side_tab[qlv_q]),
		.coord (sh_coord),
		.frac  (sh_frac)
	);

	// lerp operands: column pairs along y first, then across x
	logic signed [HGT_W-1:0] lp_a, lp_b, lp_y;
	logic [FRC_W-1:0]        lp_f;

	always_comb begin
		lp_f = fy_q;
		unique case (stp_q)
			3'd0: begin
				lp_a = $signed(c_q[0][15:0]);
				lp_b = $signed(c_q[2][15:0]);
			end
			3'd1: begin
				lp_a = $signed(c_q[0][31:16]);
				lp_b = $signed(c_q[2][31:16]);
			end
			3'd2: begin
				lp_a = $signed(c_q[1][15:0]);
				lp_b = $signed(c_q[3][15:0]);
			end
			3'd3: begin
				lp_a = $signed(c_q[1][31:16]);
				lp_b = $signed(c_q[3][31:16]);
			end
			3'd4: begin
				lp_a = t_q[0];
				lp_b = t_q[2];
				lp_f = fx_q;
			end
			default: begin
				lp_a = t_q[1];
				lp_b = t_q[3];
				lp_f = fx_q;
			end
		endcase
	end

	mmhp_lerp u_lerp (
		.a (lp_a),
		.b (lp_b),
		.f (lp_f),
		.y (lp_y)
	);

	logic signed [HGT_W-1:0] pm_min, pm_max, rd_min, rd_max;

	always_comb begin
		pm_min = $signed(c_q[0][15:0]);
		pm_max = $signed(c_q[0][31:16]);
		for (int i = 1; i < 4; i++) begin
			if ($signed(c_q[i][15:0]) < pm_min) pm_min = $signed(c_q[i][15:0]);
			if ($signed(c_q[i][31:16]) > pm_max) pm_max = $signed(c_q[i][31:16]);
		end
		rd_min = $signed(mem_rdata[15:0]);
		rd_max = $signed(mem_rdata[31:16]);
	end

	logic in_acc, out_free;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			chunk_q    <= CHUNK_RESET;
			down_q     <= '0;
			up_q       <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= $signed(cfg_data);
				CFG_ORIGIN_Y: origin_y_q <= $signed(cfg_data);
				CFG_CHUNK:    chunk_q    <= cfg_data[CHK_W-1:0];
				CFG_DOWN:     down_q     <= cfg_data[OFS_W-1:0];
				CFG_UP:       up_q       <= cfg_data[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			stp_q       <= '0;
			clr_q       <= '0;
			wk_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					stp_q <= '0;
					if (in_acc) begin
						if (op == OP_WRITE) begin
							if (32'(cell_x) < 32'(GRID_SIDE) && 32'(cell_y) < 32'(GRID_SIDE))
								state_q <= ST_WBASE;
						end else if (op == OP_PATCH || op == OP_POINT) begin
							// top level and above read the single top cell
							if (32'(level) >= 32'(LEVEL_COUNT - 1)) state_q <= ST_QRD;
							else state_q <= ST_QSH;
						end
					end
				end
				ST_WBASE: begin
					wk_q    <= LW'(1);
					state_q <= ST_WRD;
				end
				ST_WRD: begin
					stp_q <= stp_q + 3'd1;
					if (stp_q == 3'd4) state_q <= ST_WWR;
				end
				ST_WWR: begin
					stp_q <= '0;
					if (32'(wk_q) == LEVEL_COUNT - 1) begin
						state_q <= ST_IDLE;
					end else begin
						wk_q    <= wk_q + LW'(1);
						state_q <= ST_WRD;
					end
				end
				ST_QSH: begin
					stp_q <= stp_q + 3'd1;
					if (stp_q == 3'd3) begin
						stp_q   <= '0;
						state_q <= ST_QRD;
					end
				end
				ST_QRD: begin
					stp_q <= stp_q + 3'd1;
					if (stp_q == 3'd4) begin
						stp_q   <= '0;
						state_q <= ST_QCMB;
					end
				end
				ST_QCMB: begin
					stp_q <= stp_q + 3'd1;
					if (!point_q || stp_q == 3'd5) state_q <= ST_QFIN;
				end
				ST_QFIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cx_q    <= CW'(cell_x);
				cy_q    <= CW'(cell_y);
				wdat_q  <= {height_max, height_min};
				point_q <= (op == OP_POINT);
				px_q    <= pos_x;
				py_q    <= pos_y;
				ext_q   <= patch_extent;
				qlv_q   <= (32'(level) >= 32'(LEVEL_COUNT - 1)) ? LW'(LEVEL_COUNT - 1)
				                                                 : LW'(level);
				sx_q    <= '0;
				sy_q    <= '0;
				ex_q    <= '0;
				ey_q    <= '0;
				fx_q    <= '0;
				fy_q    <= '0;
			end
			ST_WRD: begin
				if (stp_q != 3'd0) begin
					if (stp_q == 3'd1 || rd_min < acc_min_q) acc_min_q <= rd_min;
					if (stp_q == 3'd1 || rd_max > acc_max_q) acc_max_q <= rd_max;
				end
			end
			ST_QSH: begin
				unique case (stp_q[1:0])
					2'd0: begin
						sx_q <= sh_coord;
						fx_q <= sh_frac;
					end
					2'd1: begin
						sy_q <= sh_coord;
						fy_q <= sh_frac;
					end
					2'd2: ex_q <= sh_coord;
					default: ey_q <= sh_coord;
				endcase
			end
			ST_QRD: begin
				if (stp_q != 3'd0) c_q[stp_q[1:0] - 2'd1] <= mem_rdata;
			end
			ST_QCMB: begin
				if (!point_q) begin
					res_min_q <= pm_min;
					res_max_q <= pm_max;
				end else if (stp_q == 3'd4) begin
					res_min_q <= lp_y;
				end else if (stp_q == 3'd5) begin
					res_max_q <= lp_y;
				end else begin
					t_q[stp_q[1:0]] <= lp_y;
				end
			end
			ST_QFIN: begin
				if (out_free) begin
					out_min_q <= OUT_W'(res_min_q) - $signed(OUT_W'(down_q));
					out_max_q <= OUT_W'(res_max_q) + $signed(OUT_W'(up_q));
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_min   = out_min_q;
	assign out_max   = out_max_q;

endmodule

[sv/mmhp_mem.sv]
// single-port pyramid store with registered read data
module mmhp_mem #(
	parameter int DEPTH = 5461,
	parameter int AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [31:0]   wdata,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

[sv/mmhp_shift.sv]
// shared floor-shift and clamp unit turning a world offset into a cell coordinate
module mmhp_shift import mmhp_pkg::*; #(
	parameter int CW = 6
) (
	input  logic signed [SHV_W-1:0] val,
	input  logic [SHA_W-1:0]        amt,
	input  logic                    point,
	input  logic                    inc,
	input  logic [CW:0]             side,
	output logic [CW-1:0]           coord,
	output logic [FRC_W-1:0]        frac
);

	logic signed [SHV_W-1:0] t;
	logic signed [SHV_W:0]   te;
	logic signed [SHV_W:0]   c;
	logic signed [SHV_W:0]   c2;
	logic signed [SHV_W:0]   lim;

	always_comb begin
		t    = val >>> amt;
		frac = t[FRC_W-1:0];
		te   = (SHV_W+1)'(t);
		c    = point ? (te >>> FRC_W) : te;
		c2   = c + (SHV_W+1)'(inc && point && (frac != '0));
		lim  = $signed((SHV_W+1)'(side)) - (SHV_W+1)'(1);
		if (c2 < 0) begin
			coord = '0;
		end else if (c2 > lim) begin
			coord = CW'(lim);
		end else begin
			coord = CW'(c2);
		end
	end

endmodule

[sv/mmhp_lerp.sv]
// shared 8-bit fraction lerp, rounding toward minus infinity
module mmhp_lerp import mmhp_pkg::*; (
	input  logic signed [HGT_W-1:0] a,
	input  logic signed [HGT_W-1:0] b,
	input  logic [FRC_W-1:0]        f,
	output logic signed [HGT_W-1:0] y
);

	logic signed [HGT_W:0]         d;
	logic signed [HGT_W+FRC_W+1:0] p;
	logic signed [HGT_W+FRC_W+1:0] r;

	always_comb begin
		d = (HGT_W+1)'(b) - (HGT_W+1)'(a);
		p = (HGT_W+FRC_W+2)'(d) * $signed({2'b0, f});
		r = (HGT_W+FRC_W+2)'(a) + (p >>> FRC_W);
		y = r[HGT_W-1:0];
	end

endmodule

[tb/mmhp_height_checker.sv]
// checker for the min/max height pyramid: mirrors the store, predicts query results and compares
`timescale 1ns / 100ps

module mmhp_height_checker import mmhp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IW-1:0]       cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic [1:0]              op,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	input  logic signed [HGT_W-1:0] height_min,
	input  logic signed [HGT_W-1:0] height_max,
	input  logic [LVL_W-1:0]        level,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic [EXT_W-1:0]        patch_extent,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic signed [OUT_W-1:0] out_min,
	input  logic signed [OUT_W-1:0] out_max,
	output int                      fail_count,
	output int                      pending
);

	localparam int LVLS  = LEVEL_COUNT_DEF;
	localparam int GRID  = GRID_SIDE_DEF;
	localparam int DEPTH = store_depth(GRID, LVLS);

	typedef struct packed {
		logic [OUT_W-1:0] lo;
		logic [OUT_W-1:0] hi;
	} height_pair_t;

	logic [31:0]        heights [DEPTH];
	logic signed [31:0] org_x, org_y;
	logic [CHK_W-1:0]   chunk;
	logic [OFS_W-1:0]   down_ofs, up_ofs;
	height_pair_t       expected_heights [$];

	function automatic longint lo_of(input logic [31:0] e);
		return longint'($signed(e[15:0]));
	endfunction

	function automatic longint hi_of(input logic [31:0] e);
		return longint'($signed(e[31:16]));
	endfunction

	function automatic longint clamp_cell(input longint v, input int side);
		if (v < 0) return 0;
		if (v > side - 1) return side - 1;
		return v;
	endfunction

	function automatic logic [31:0] cell_at(input int lv, input longint x, input longint y);
		return heights[lvl_base(GRID, lv) + int'(y) * lvl_side(GRID, lv) + int'(x)];
	endfunction

	function automatic longint lerp8(input longint a, input longint b, input longint f);
		return a + (((b - a) * f) >>> 8);
	endfunction

	// base write, then rebuild each parent from its four (edge clamped) children
	task automatic store_cell(input int cx, input int cy, input logic [15:0] mn,
			input logic [15:0] mx);
		longint px, py, lo, hi;
		logic [31:0] e;
		heights[cy * GRID + cx] = {mx, mn};
		for (int k = 1; k < LVLS; k++) begin
			px = clamp_cell(cx >> k, lvl_side(GRID, k));
			py = clamp_cell(cy >> k, lvl_side(GRID, k));
			for (int d = 0; d < 4; d++) begin
				e = cell_at(k - 1, clamp_cell(px * 2 + d % 2, lvl_side(GRID, k - 1)),
					clamp_cell(py * 2 + d / 2, lvl_side(GRID, k - 1)));
				if (d == 0 || lo_of(e) < lo) lo = lo_of(e);
				if (d == 0 || hi_of(e) > hi) hi = hi_of(e);
			end
			heights[lvl_base(GRID, k) + int'(py) * lvl_side(GRID, k) + int'(px)] =
				{hi[15:0], lo[15:0]};
		end
	endtask

	function automatic height_pair_t predict_heights(input logic [1:0] qop, input int lv,
			input longint wx, input longint wy, input longint ext);
		longint rx, ry, sx, sy, ex, ey, fx, fy, tx, ty, lo, hi, l0, l1, h0, h1;
		logic [31:0] c00, c10, c01, c11;
		int sh, side;
		height_pair_t r;
		rx = wx - longint'(org_x);
		ry = wy - longint'(org_y);
		fx = 0;
		fy = 0;
		if (lv >= LVLS - 1) begin
			c00 = heights[lvl_base(GRID, LVLS - 1)];
			lo = lo_of(c00);
			hi = hi_of(c00);
		end else begin
			sh = int'(chunk) + lv;
			side = lvl_side(GRID, lv);
			if (qop == OP_PATCH) begin
				sx = rx >>> sh;
				sy = ry >>> sh;
				ex = (rx + ext) >>> sh;
				ey = (ry + ext) >>> sh;
			end else begin
				tx = (rx * 256) >>> sh;
				ty = (ry * 256) >>> sh;
				fx = tx & 255;
				fy = ty & 255;
				sx = tx >>> 8;
				sy = ty >>> 8;
				ex = sx + (fx != 0);
				ey = sy + (fy != 0);
			end
			sx = clamp_cell(sx, side);
			sy = clamp_cell(sy, side);
			ex = clamp_cell(ex, side);
			ey = clamp_cell(ey, side);
			c00 = cell_at(lv, sx, sy);
			c10 = cell_at(lv, ex, sy);
			c01 = cell_at(lv, sx, ey);
			c11 = cell_at(lv, ex, ey);
			if (sx == ex && sy == ey) begin
				lo = lo_of(c00);
				hi = hi_of(c00);
			end else if (qop == OP_PATCH) begin
				lo = lo_of(c00);
				hi = hi_of(c00);
				if (lo_of(c10) < lo) lo = lo_of(c10);
				if (lo_of(c01) < lo) lo = lo_of(c01);
				if (lo_of(c11) < lo) lo = lo_of(c11);
				if (hi_of(c10) > hi) hi = hi_of(c10);
				if (hi_of(c01) > hi) hi = hi_of(c01);
				if (hi_of(c11) > hi) hi = hi_of(c11);
			end else begin
				// column pairs first, then across
				l0 = lerp8(lo_of(c00), lo_of(c01), fy);
				h0 = lerp8(hi_of(c00), hi_of(c01), fy);
				l1 = lerp8(lo_of(c10), lo_of(c11), fy);
				h1 = lerp8(hi_of(c10), hi_of(c11), fy);
				lo = lerp8(l0, l1, fx);
				hi = lerp8(h0, h1, fx);
			end
		end
		lo = lo - longint'(down_ofs);
		hi = hi + longint'(up_ofs);
		r.lo = lo[OUT_W-1:0];
		r.hi = hi[OUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		height_pair_t got, want;
		int errs;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) heights[i] = '0;
			org_x = '0;
			org_y = '0;
			chunk = CHUNK_RESET;
			down_ofs = '0;
			up_ofs = '0;
			expected_heights.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ORIGIN_X: org_x = cfg_data;
					CFG_ORIGIN_Y: org_y = cfg_data;
					CFG_CHUNK:    chunk = cfg_data[CHK_W-1:0];
					CFG_DOWN:     down_ofs = cfg_data[OFS_W-1:0];
					CFG_UP:       up_ofs = cfg_data[OFS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.lo = out_min;
				got.hi = out_max;
				if (expected_heights.size() == 0) begin
					$error("result beat with nothing expected: min %0d max %0d",
						$signed(got.lo), $signed(got.hi));
					errs++;
				end else begin
					want = expected_heights.pop_front();
					if (got.lo !== want.lo) begin
						$error("out_min: expected %0d, got %0d", $signed(want.lo),
							$signed(got.lo));
						errs++;
					end
					if (got.hi !== want.hi) begin
						$error("out_max: expected %0d, got %0d", $signed(want.hi),
							$signed(got.hi));
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (op == OP_WRITE)
					store_cell(int'(cell_x), int'(cell_y), height_min, height_max);
				else if (op == OP_PATCH || op == OP_POINT)
					expected_heights.push_back(predict_heights(op, int'(level),
						longint'(pos_x), longint'(pos_y), longint'(patch_extent)));
			end
			fail_count <= fail_count + errs;
			pending <= expected_heights.size();
		end
	end

endmodule

[tb/tb_minmax_height_pyramid_core.sv]
// testbench top: stimulus, configuration phases, output stalls and verdict for the height pyramid
`timescale 1ns / 100ps

module tb_minmax_height_pyramid_core;
	import mmhp_pkg::*;

	localparam int PHASES    = 5;
	localparam int PER_PHASE = 206;
	localparam int LIMIT     = 600000;

	logic                    clk, arst_n;
	logic                    cfg_valid, cfg_ready;
	logic [CFG_IW-1:0]       cfg_index;
	logic [31:0]             cfg_data;
	logic                    in_valid, in_ready;
	logic [1:0]              op;
	logic [CELL_W-1:0]       cell_x, cell_y;
	logic signed [HGT_W-1:0] height_min, height_max;
	logic [LVL_W-1:0]        level;
	logic signed [POS_W-1:0] pos_x, pos_y;
	logic [EXT_W-1:0]        patch_extent;
	logic                    out_valid, out_ready;
	logic signed [OUT_W-1:0] out_min, out_max;
	int                      fail_count, pending, cycles;

	// stimulus side view of the configuration, used to aim points at the grid
	logic signed [31:0] cur_ox, cur_oy;
	int                 cur_chunk;
	bit                 no_idle, hold_req, hold_done;

	minmax_height_pyramid_core uut (.*);

	mmhp_height_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("minmax_height_pyramid_core test failed");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off so the block backs up
	initial begin
		out_ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
			end
			out_ready <= no_idle || ($urandom_range(0, 99) >= 8);
		end
	end

	task automatic reg_write(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy, input int ch,
			input logic [31:0] dn, input logic [31:0] upo);
		reg_write(CFG_ORIGIN_X, ox);
		reg_write(CFG_ORIGIN_Y, oy);
		reg_write(CFG_CHUNK, 32'(ch));
		reg_write(CFG_DOWN, dn);
		reg_write(CFG_UP, upo);
		cfg_valid <= 1'b0;
		cur_ox = ox;
		cur_oy = oy;
		cur_chunk = ch;
	endtask

	task automatic send_beat(input logic [1:0] o, input int cx, input int cy,
			input logic [15:0] hmn, input logic [15:0] hmx, input int lv,
			input logic [31:0] x, input logic [31:0] y, input logic [30:0] ext);
		in_valid <= 1'b1;
		op <= o;
		cell_x <= CELL_W'(cx);
		cell_y <= CELL_W'(cy);
		height_min <= hmn;
		height_max <= hmx;
		level <= LVL_W'(lv);
		pos_x <= x;
		pos_y <= y;
		patch_extent <= ext;
		do @(posedge clk); while (!in_ready);
		if (!no_idle && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] aim(input logic signed [31:0] org, input int lv);
		longint span;
		if ($urandom_range(0, 99) < 12) return $urandom;
		span = longint'(64) << (cur_chunk + lv);
		return org + 32'(longint'($urandom_range(0, 32'(span * 5 / 4))) - span / 8);
	endfunction

	task automatic random_beat();
		int pick, lv;
		logic [30:0] ext;
		pick = $urandom_range(0, 99);
		lv = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
		ext = ($urandom_range(0, 9) < 7) ?
			31'($urandom_range(0, 32'((longint'(64) << (cur_chunk + lv)) / 2))) :
			31'($urandom);
		if (pick < 40)
			send_beat(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom,
				$urandom, lv, $urandom, $urandom, $urandom);
		else if (pick < 95)
			send_beat(pick < 65 ? OP_PATCH : OP_POINT, $urandom, $urandom, $urandom,
				$urandom, lv, aim(cur_ox, lv), aim(cur_oy, lv), ext);
		else
			send_beat(2'd3, $urandom, $urandom, $urandom, $urandom, lv, $urandom,
				$urandom, $urandom);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// a write leaves no result but keeps the block busy for a while
		repeat (60) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_WRITE;
		cell_x = '0;
		cell_y = '0;
		height_min = '0;
		height_max = '0;
		level = '0;
		pos_x = '0;
		pos_y = '0;
		patch_extent = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_grid(32'd0, 32'd0, 8, 32'd0, 32'd0);
		// directed: extreme heights at the corners, unordered cell, every query shape
		send_beat(OP_PATCH, 0, 0, 0, 0, 0, 32'd0, 32'd0, 31'd0);
		send_beat(OP_WRITE, 0, 0, 16'h8000, 16'h7fff, 0, 0, 0, 0);
		send_beat(OP_WRITE, 63, 63, 16'h7fff, 16'h8000, 0, 0, 0, 0);
		send_beat(OP_WRITE, 63, 0, 16'd100, 16'd200, 0, 0, 0, 0);
		send_beat(OP_WRITE, 0, 63, -16'sd5, 16'd5, 0, 0, 0, 0);
		send_beat(OP_WRITE, 5, 7, -16'sd300, 16'd900, 0, 0, 0, 0);
		send_beat(OP_WRITE, 6, 7, 16'd50, 16'd60, 0, 0, 0, 0);
		send_beat(OP_PATCH, 0, 0, 0, 0, 0, 32'd0, 32'd0, 31'd0);
		send_beat(OP_PATCH, 0, 0, 0, 0, 0, -32'sd1000, -32'sd1000, 31'd20000);
		send_beat(OP_PATCH, 0, 0, 0, 0, 6, 32'd0, 32'd0, 31'd0);
		send_beat(OP_POINT, 0, 0, 0, 0, 15, 32'd0, 32'd0, 31'd0);
		send_beat(OP_POINT, 0, 0, 0, 0, 0, 32'd1408, 32'd1856, 31'd0);
		send_beat(OP_POINT, 0, 0, 0, 0, 0, 32'd1280, 32'd1792, 31'd0);
		send_beat(OP_POINT, 0, 0, 0, 0, 2, 32'd3000, 32'd9000, 31'd0);
		send_beat(OP_POINT, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 31'd0);
		send_beat(OP_PATCH, 0, 0, 0, 0, 1, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
		send_beat(OP_PATCH, 0, 0, 0, 0, 0, 32'd16000, 32'd0, 31'h7fffffff);
		send_beat(2'd3, 63, 63, 16'hffff, 16'hffff, 15, 32'hffffffff, 32'hffffffff,
			31'h7fffffff);
		send_beat(OP_POINT, 0, 0, 0, 0, 5, 32'd100, 32'd100, 31'd0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ;
				1: begin
					reg_write(3'd5, $urandom);
					reg_write(3'd7, $urandom);
					set_grid(32'h80000000, 32'h7fffffff, 0, 32'd32767, 32'd32767);
				end
				2: begin
					set_grid($urandom, $urandom, 24, $urandom_range(0, 32767),
						$urandom_range(0, 32767));
					hold_req = 1'b1;
				end
				3: begin
					set_grid(32'd1000, -32'sd5000, 3, 32'd1, 32'd2);
					no_idle = 1'b1;
				end
				default: set_grid($urandom, $urandom, $urandom_range(0, 24), $urandom,
					$urandom);
			endcase
			for (int n = 0; n < PER_PHASE; n++) random_beat();
			drain();
			no_idle = 1'b0;
		end

		if (fail_count == 0)
			$display("minmax_height_pyramid_core test passed");
		else
			$display("minmax_height_pyramid_core test failed");
		$finish;
	end

endmodule
